[hdl/ffol_pkg.sv]
// ----------------------------------------------------------------------------
// ffol_pkg
// Shared types and codes for the first-come ownership lock: request modes,
// result codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ffol_pkg;

    // request modes (the unused code is answered as a query)
    localparam logic [1:0] MODE_ACQUIRE = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_QUERY   = 2'd2;

    // result codes
    typedef enum logic [2:0] {
        RES_ACQUIRED = 3'd0,
        RES_PENDING  = 3'd1,
        RES_RELEASED = 3'd2,
        RES_FULL     = 3'd3,
        RES_QUERY    = 3'd4
    } result_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_SCAN,
        S_COMMIT,
        S_FINISH
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    grant;
        logic    clear_owner;
        logic    scan_start;
        logic    scan_compact;
        logic    scan_drop_head;
        logic    scan_run;
        logic    commit_enqueue;
        logic    commit_compact;
        logic    commit_handoff;
        logic    finish;
        result_t result;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] mode;
        logic       owner_free;
        logic       owner_match;
        logic       queue_empty;
        logic       queue_full;
        logic       scan_done;
        logic       found;
        logic       out_busy;
    } stat_t;

endpackage

`default_nettype wire

[hdl/ffol_ctrl.sv]
// ----------------------------------------------------------------------------
// ffol_ctrl
// Sequencer for the ownership lock: decodes a request, starts the queue walk
// when one is needed, commits its outcome and hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module ffol_ctrl
    import ffol_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    state_t  state_reg, state_next;
    result_t result_reg, result_next;

    // state and result code registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            result_reg <= RES_QUERY;
        end else begin
            state_reg  <= state_next;
            result_reg <= result_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next  = state_reg;
        result_next = result_reg;
        cmd         = '0;
        cmd.result  = result_reg;
        s_tready    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EVAL;
                end
            end

            S_EVAL: begin
                unique case (stat.mode)
                    MODE_ACQUIRE: begin
                        if (stat.owner_free && stat.queue_empty) begin
                            cmd.grant   = 1'b1;
                            result_next = RES_ACQUIRED;
                            state_next  = S_FINISH;
                        end else if (stat.owner_match) begin
                            result_next = RES_ACQUIRED;
                            state_next  = S_FINISH;
                        end else begin
                            // search the queue for the client
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    MODE_RELEASE: begin
                        result_next = RES_RELEASED;
                        if (stat.owner_match && stat.queue_empty) begin
                            cmd.clear_owner = 1'b1;
                            state_next      = S_FINISH;
                        end else begin
                            // owner: pop the head; otherwise drop the client
                            cmd.scan_start     = 1'b1;
                            cmd.scan_compact   = 1'b1;
                            cmd.scan_drop_head = stat.owner_match;
                            state_next         = S_SCAN;
                        end
                    end
                    MODE_QUERY: begin
                        result_next = RES_QUERY;
                        state_next  = S_FINISH;
                    end
                    default: begin
                        result_next = RES_QUERY;
                        state_next  = S_FINISH;
                    end
                endcase
            end

            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_COMMIT;
                end
            end

            S_COMMIT: begin
                state_next = S_FINISH;
                if (stat.mode == MODE_ACQUIRE) begin
                    if (stat.found) begin
                        result_next = RES_PENDING;
                    end else if (!stat.queue_full) begin
                        cmd.commit_enqueue = 1'b1;
                        result_next        = RES_PENDING;
                    end else begin
                        result_next = RES_FULL;
                    end
                end else begin
                    cmd.commit_compact = 1'b1;
                    cmd.commit_handoff = stat.owner_match;
                end
            end

            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/ffol_dpath.sv]
// ----------------------------------------------------------------------------
// ffol_dpath
// Datapath of the ownership lock: owner registers, the wait-queue memory with
// its walk pointers, and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffol_dpath
    import ffol_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int CLIENT_ID_BITS = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cmd_t                      cmd,
    output stat_t                          stat,
    input  wire logic [1:0]                in_mode,
    input  wire logic [CLIENT_ID_BITS-1:0] in_id,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic [2:0]                     out_status,
    output logic                           out_has_control,
    output logic                           out_handoff_valid,
    output logic [CLIENT_ID_BITS-1:0]      out_handoff_client
);

    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
    localparam int IDXW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // wait-queue memory, oldest entry at index zero
    logic [CLIENT_ID_BITS-1:0] queue_mem [QUEUE_DEPTH];

    // request and lock state
    logic [1:0]                mode_reg;
    logic [CLIENT_ID_BITS-1:0] id_reg;
    logic                      owner_valid_reg;
    logic [CLIENT_ID_BITS-1:0] owner_id_reg;
    logic [CNTW-1:0]           count_reg;
    logic                      hv_reg;

    // walk state
    logic [CNTW-1:0]           rd_ptr_reg;
    logic [CNTW-1:0]           wr_ptr_reg;
    logic                      pend_valid_reg;
    logic [CNTW-1:0]           pend_idx_reg;
    logic [CLIENT_ID_BITS-1:0] rd_data_reg;
    logic                      found_reg;
    logic [CLIENT_ID_BITS-1:0] head_reg;
    logic                      compact_reg;
    logic                      drop_head_reg;

    // output register
    logic                      out_valid_reg;
    logic [2:0]                out_status_reg;
    logic                      out_has_reg;
    logic                      out_hv_reg;
    logic [CLIENT_ID_BITS-1:0] out_hc_reg;

    logic                      owner_match;
    logic                      rd_more;
    logic                      issue;
    logic                      match;
    logic                      keep_wr;
    logic                      wr_en;
    logic [IDXW-1:0]           wr_addr;
    logic [CLIENT_ID_BITS-1:0] wr_data;

    // walk control
    assign owner_match = owner_valid_reg && (owner_id_reg == id_reg);
    assign rd_more     = rd_ptr_reg < count_reg;
    assign issue       = cmd.scan_run && rd_more;
    assign match       = drop_head_reg ? (pend_idx_reg == '0) : (rd_data_reg == id_reg);
    assign keep_wr     = cmd.scan_run && pend_valid_reg && compact_reg && !match;

    // memory write: compaction during the walk, or an enqueue at commit
    assign wr_en   = keep_wr || cmd.commit_enqueue;
    assign wr_addr = keep_wr ? wr_ptr_reg[IDXW-1:0] : count_reg[IDXW-1:0];
    assign wr_data = keep_wr ? rd_data_reg : id_reg;

    always_ff @(posedge aclk) begin
        if (issue) begin
            rd_data_reg <= queue_mem[rd_ptr_reg[IDXW-1:0]];
        end
        if (wr_en) begin
            queue_mem[wr_addr] <= wr_data;
        end
    end

    // request capture, lock state and walk pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            owner_valid_reg <= 1'b0;
            owner_id_reg    <= '0;
            count_reg       <= '0;
            pend_valid_reg  <= 1'b0;
            hv_reg          <= 1'b0;
        end else begin
            if (cmd.load) begin
                mode_reg <= in_mode;
                id_reg   <= in_id;
                hv_reg   <= 1'b0;
            end
            if (cmd.grant) begin
                owner_valid_reg <= 1'b1;
                owner_id_reg    <= id_reg;
            end
            if (cmd.clear_owner) begin
                owner_valid_reg <= 1'b0;
            end

            if (cmd.scan_start) begin
                rd_ptr_reg     <= '0;
                wr_ptr_reg     <= '0;
                pend_valid_reg <= 1'b0;
                found_reg      <= 1'b0;
                compact_reg    <= cmd.scan_compact;
                drop_head_reg  <= cmd.scan_drop_head;
            end else if (cmd.scan_run) begin
                pend_valid_reg <= issue;
                pend_idx_reg   <= rd_ptr_reg;
                if (issue) begin
                    rd_ptr_reg <= rd_ptr_reg + 1'b1;
                end
                if (pend_valid_reg) begin
                    if (match) begin
                        found_reg <= 1'b1;
                    end
                    if (pend_idx_reg == '0) begin
                        head_reg <= rd_data_reg;
                    end
                    if (keep_wr) begin
                        wr_ptr_reg <= wr_ptr_reg + 1'b1;
                    end
                end
            end

            if (cmd.commit_enqueue) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.commit_compact) begin
                count_reg <= wr_ptr_reg;
            end
            if (cmd.commit_handoff) begin
                owner_id_reg <= head_reg;
                hv_reg       <= 1'b1;
            end
        end
    end

    // output register, freed when the transaction is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.finish) begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= cmd.result;
                out_has_reg    <= owner_match;
                out_hv_reg     <= hv_reg;
                out_hc_reg     <= hv_reg ? owner_id_reg : '0;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status to the controller
    always_comb begin
        stat.mode        = mode_reg;
        stat.owner_free  = !owner_valid_reg;
        stat.owner_match = owner_match;
        stat.queue_empty = (count_reg == '0);
        stat.queue_full  = (count_reg == CNTW'(QUEUE_DEPTH));
        stat.scan_done   = !rd_more && !pend_valid_reg;
        stat.found       = found_reg;
        stat.out_busy    = out_valid_reg && !out_ready;
    end

    assign out_valid          = out_valid_reg;
    assign out_status         = out_status_reg;
    assign out_has_control    = out_has_reg;
    assign out_handoff_valid  = out_hv_reg;
    assign out_handoff_client = out_hc_reg;

endmodule

`default_nettype wire

[hdl/fifo_fair_ownership_lock_unit.sv]
// ----------------------------------------------------------------------------
// fifo_fair_ownership_lock_unit
// Ownership lock with a first-come wait queue, behind stream interfaces.
// ----------------------------------------------------------------------------
// Each request carries a mode (acquire, release, query) and a client id and
// yields exactly one result transaction. Requests that need no look at the
// wait queue (any query, a grant of a free lock, an acquire by the owner, a
// release by the owner with nobody waiting) go from decode straight to the
// finish state; requests that walk the queue pass through the scan and commit
// states, where the wait-queue memory is read one entry per cycle through its
// single registered read port and compacted in place through its write port.
// No request is accepted before the last result enters the output register,
// where it waits while the next request is accepted. The queue memory needs
// no clearing after reset: only entries below the fill count are ever read.
`default_nettype none

module fifo_fair_ownership_lock_unit
    import ffol_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int CLIENT_ID_BITS = 8
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    // s_tdata: mode[1:0], client_id, zero padding
    input  wire logic [((CLIENT_ID_BITS+9)/8)*8-1:0]    s_tdata,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // m_tdata: status[2:0], has_control, handoff_valid, handoff_client, zero padding
    output logic [((CLIENT_ID_BITS+12)/8)*8-1:0]        m_tdata,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready
);

    localparam int OUT_W = ((CLIENT_ID_BITS + 12) / 8) * 8;
    localparam int PAY_W = CLIENT_ID_BITS + 5;

    cmd_t                      cmd;
    stat_t                     stat;
    logic [2:0]                out_status;
    logic                      out_has_control;
    logic                      out_handoff_valid;
    logic [CLIENT_ID_BITS-1:0] out_handoff_client;

    // sequencer
    ffol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // lock state, queue memory and output register
    ffol_dpath #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .CLIENT_ID_BITS (CLIENT_ID_BITS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .in_mode            (s_tdata[1:0]),
        .in_id              (s_tdata[2 +: CLIENT_ID_BITS]),
        .out_ready          (m_tready),
        .out_valid          (m_tvalid),
        .out_status         (out_status),
        .out_has_control    (out_has_control),
        .out_handoff_valid  (out_handoff_valid),
        .out_handoff_client (out_handoff_client)
    );

    // result packing
    logic [PAY_W-1:0] payload;
    assign payload = {out_handoff_client, out_handoff_valid, out_has_control, out_status};
    assign m_tdata = OUT_W'(payload);

endmodule

`default_nettype wire

[verif/ffol_lock_checker.sv]
// ----------------------------------------------------------------------------
// ffol_lock_checker
// Watches both stream channels of the ownership lock, predicts the answer to
// every accepted request from its own copy of the owner and wait queue, and
// compares each answer field by field in arrival order.
// ----------------------------------------------------------------------------
module ffol_lock_checker
    import ffol_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // s_tdata: mode[1:0], client_id[9:2], zero padding
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    // m_tdata: status[2:0], has_control, handoff_valid, handoff_client[12:5], padding
    input  wire logic [15:0] m_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    output int               fail_count,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_SIZE = 64;

    // lowest field last, so that status lands in the low bits
    typedef struct packed {
        logic [7:0] handoff_client;
        logic       handoff_valid;
        logic       has_control;
        result_t    status;
    } lock_answer_t;

    // shadow of the lock state
    logic       owner_held;
    logic [7:0] owner_client;
    logic [7:0] waiters [QUEUE_DEPTH];
    int         waiter_count;

    // expected answers in request order
    lock_answer_t answer_ring [RING_SIZE];
    int           ring_wr;
    int           ring_rd;

    function automatic bit client_waiting(input logic [7:0] client);
        for (int i = 0; i < waiter_count; i++)
            if (waiters[i] == client)
                return 1'b1;
        return 1'b0;
    endfunction

    // works out the answer to one request and moves the shadow state on
    function automatic lock_answer_t predict_lock_answer(input logic [1:0] mode,
                                                         input logic [7:0] client);
        lock_answer_t ans;
        int           keep;
        ans = '0;
        case (mode)
            MODE_ACQUIRE: begin
                if (!owner_held && waiter_count == 0) begin
                    owner_held   = 1'b1;
                    owner_client = client;
                    ans.status   = RES_ACQUIRED;
                end else if (owner_held && owner_client == client) begin
                    ans.status = RES_ACQUIRED;
                end else if (client_waiting(client)) begin
                    ans.status = RES_PENDING;
                end else if (waiter_count < QUEUE_DEPTH) begin
                    waiters[waiter_count] = client;
                    waiter_count++;
                    ans.status = RES_PENDING;
                end else begin
                    ans.status = RES_FULL;
                end
            end
            MODE_RELEASE: begin
                if (owner_held && owner_client == client) begin
                    if (waiter_count == 0) begin
                        owner_held = 1'b0;
                    end else begin
                        // head of the queue takes over
                        owner_client = waiters[0];
                        for (int i = 1; i < waiter_count; i++)
                            waiters[i-1] = waiters[i];
                        waiter_count--;
                        ans.handoff_valid  = 1'b1;
                        ans.handoff_client = owner_client;
                    end
                end else begin
                    // drop the client from the queue, keeping the order
                    keep = 0;
                    for (int i = 0; i < waiter_count; i++)
                        if (waiters[i] != client) begin
                            waiters[keep] = waiters[i];
                            keep++;
                        end
                    waiter_count = keep;
                end
                ans.status = RES_RELEASED;
            end
            default: ans.status = RES_QUERY;
        endcase
        ans.has_control = owner_held && owner_client == client;
        return ans;
    endfunction

    // predict on request transactions, compare on answer transactions
    always @(posedge aclk) begin
        lock_answer_t want;
        lock_answer_t got;
        int           errors;
        errors = 0;
        if (!aresetn) begin
            owner_held   = 1'b0;
            owner_client = '0;
            waiter_count = 0;
            ring_wr      = 0;
            ring_rd      = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                answer_ring[ring_wr % RING_SIZE] =
                    predict_lock_answer(s_tdata[1:0], s_tdata[9:2]);
                ring_wr++;
            end
            if (m_tvalid && m_tready) begin
                got = lock_answer_t'(m_tdata[12:0]);
                if (ring_wr == ring_rd) begin
                    $error("answer transaction with none expected: %h", m_tdata);
                    errors++;
                end else begin
                    want = answer_ring[ring_rd % RING_SIZE];
                    ring_rd++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.has_control !== want.has_control) begin
                        $error("has_control: expected %0d, got %0d",
                               want.has_control, got.has_control);
                        errors++;
                    end
                    if (got.handoff_valid !== want.handoff_valid) begin
                        $error("handoff_valid: expected %0d, got %0d",
                               want.handoff_valid, got.handoff_valid);
                        errors++;
                    end
                    if (got.handoff_client !== want.handoff_client) begin
                        $error("handoff_client: expected %0d, got %0d",
                               want.handoff_client, got.handoff_client);
                        errors++;
                    end
                    if (m_tdata[15:13] !== 3'b000) begin
                        $error("padding: expected 0, got %0d", m_tdata[15:13]);
                        errors++;
                    end
                end
            end
        end
        fail_count  <= fail_count + errors;
        outstanding <= ring_wr - ring_rd;
    end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives lock requests into the ownership lock through its stream input,
// with random gaps and back-pressure, and leaves checking to the checker.
// ----------------------------------------------------------------------------
module testbench
    import ffol_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 2000;
    localparam int         HOLD_CYCLES = 300;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    int fail_count;
    int outstanding;

    // idling and hold-off controls shared with the receiver
    int   tx_idle_pct  = 0;
    int   rx_idle_pct  = 0;
    logic hold_request = 1'b0;
    logic hold_armed   = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    logic [7:0] client_pool [24];
    int         pool_size;

    fifo_fair_ownership_lock_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    ffol_lock_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // receiver: random stalls, plus one long hold-off when asked
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= (int'($urandom_range(0, 99)) >= rx_idle_pct);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // offer one request, with a random gap first, and wait for acceptance
    task automatic send_request(input logic [1:0] mode, input logic [7:0] client);
        while (int'($urandom_range(0, 99)) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {6'b0, client, mode};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    // sender pause until every answer is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic refill_pool();
        pool_size = int'($urandom_range(17, 24));
        for (int i = 0; i < pool_size; i++)
            client_pool[i] = 8'($urandom_range(0, 255));
    endtask

    // mostly contended traffic on a small set of clients, some from anywhere
    task automatic random_requests(input int count);
        int         pick;
        logic [1:0] mode;
        logic [7:0] client;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0)
                refill_pool();
            if (n % 250 == 249)
                wait_drained();
            pick = int'($urandom_range(0, 99));
            if (pick < 50)
                mode = MODE_ACQUIRE;
            else if (pick < 85)
                mode = MODE_RELEASE;
            else if (pick < 95)
                mode = MODE_QUERY;
            else
                mode = MODE_UNUSED;
            if ($urandom_range(0, 9) == 0)
                client = 8'($urandom_range(0, 255));
            else
                client = client_pool[$urandom_range(0, pool_size - 1)];
            send_request(mode, client);
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: grant, re-acquire, queries, unused mode, free release
        tx_idle_pct <= 7;
        rx_idle_pct <= 76;
        send_request(MODE_ACQUIRE, 8'd0);
        send_request(MODE_ACQUIRE, 8'd0);
        send_request(MODE_QUERY, 8'd0);
        send_request(MODE_QUERY, 8'd5);
        send_request(MODE_UNUSED, 8'd5);
        send_request(MODE_RELEASE, 8'd0);
        send_request(MODE_ACQUIRE, 8'd0);
        // fill the wait queue, then overflow it
        for (int c = 1; c <= 16; c++)
            send_request(MODE_ACQUIRE, c[7:0]);
        send_request(MODE_ACQUIRE, 8'd255);
        // already waiting, stranger release, drop from the middle, handoff
        send_request(MODE_ACQUIRE, 8'd3);
        send_request(MODE_RELEASE, 8'd200);
        send_request(MODE_RELEASE, 8'd7);
        send_request(MODE_RELEASE, 8'd0);
        wait_drained();

        // random: sender mostly busy, receiver mostly stalled
        random_requests(650);
        wait_drained();

        // random: sender mostly idle, receiver mostly ready
        tx_idle_pct <= 76;
        rx_idle_pct <= 7;
        random_requests(650);
        wait_drained();

        // random: no idling, with one long receiver hold-off
        tx_idle_pct  <= 0;
        rx_idle_pct  <= 0;
        hold_request <= 1'b1;
        random_requests(650);

        wait_drained();
        repeat (30) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
